[hw/rtl/pes_pkg.sv]
`timescale 1ns / 1ps
// Package for the periodic event scheduler: sizes, codes, sequencer states
// and the request/response structs of the shared remainder unit. No dependencies.
package pes_pkg;

    localparam int SLOTS           = 16;
    localparam int PRIORITY_LEVELS = 4;
    localparam int MAX_RESULTS     = 16;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(MAX_RESULTS + 1);
    localparam int WORD_W = 32;
    localparam int HND_W  = 16;
    localparam int PRIO_W = 2;
    localparam int STAT_W = 2;
    localparam int OSLOT_W = 4;
    localparam int BIT_W  = $clog2(WORD_W);

    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_STORED  = 2'd0,
        ST_FULL    = 2'd1,
        ST_FIRED   = 2'd2,
        ST_NOTHING = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_WAIT = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] dividend;
        logic [WORD_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic done;
        logic rem_zero;
    } div_rsp_t;

endpackage

[hw/rtl/pes_cmd_if.sv]
`timescale 1ns / 1ps
// Input channel of the scheduler: valid/ready plus one add or tick beat.
// Depends on pes_pkg.
interface pes_cmd_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [pes_pkg::HND_W-1:0]    handler_id;
    logic [pes_pkg::WORD_W-1:0]   context_req;
    logic [pes_pkg::PRIO_W-1:0]   priority_req;
    logic [pes_pkg::WORD_W-1:0]   interval;

    modport source (output valid, kind, handler_id, context_req, priority_req, interval,
                    input ready);
    modport sink   (input valid, kind, handler_id, context_req, priority_req, interval,
                    output ready);
endinterface

[hw/rtl/pes_evt_if.sv]
`timescale 1ns / 1ps
// Result channel of the scheduler: valid/ready plus one result beat.
// Depends on pes_pkg.
interface pes_evt_if;
    logic                          valid;
    logic                          ready;
    logic [pes_pkg::STAT_W-1:0]    status;
    logic [pes_pkg::OSLOT_W-1:0]   slot;
    logic [pes_pkg::HND_W-1:0]     fired_handler;
    logic [pes_pkg::WORD_W-1:0]    fired_context;
    logic [pes_pkg::WORD_W-1:0]    tick_count;
    logic                          last;

    modport source (output valid, status, slot, fired_handler, fired_context, tick_count,
                    last, input ready);
    modport sink   (input valid, status, slot, fired_handler, fired_context, tick_count,
                    last, output ready);
endinterface

[hw/rtl/pes_mod_unit.sv]
`timescale 1ns / 1ps
// Bit-serial remainder unit: dividend mod divisor, one quotient bit per cycle.
// Depends on pes_pkg.
module pes_mod_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  pes_pkg::div_req_t req,
    output pes_pkg::div_rsp_t rsp
);

    logic                         busy_reg;
    logic                         done_reg;
    logic [pes_pkg::BIT_W-1:0]    cnt_reg;
    logic [pes_pkg::WORD_W-1:0]   num_reg;
    logic [pes_pkg::WORD_W-1:0]   den_reg;
    logic [pes_pkg::WORD_W-1:0]   rem_reg;
    logic [pes_pkg::WORD_W-1:0]   rem_next;
    logic [pes_pkg::WORD_W:0]     trial;

    // restoring step: shift in next dividend bit, subtract if it fits
    always_comb
    begin
        trial = {rem_reg, num_reg[pes_pkg::WORD_W-1]};
        if (trial >= {1'b0, den_reg})
        begin
            rem_next = pes_pkg::WORD_W'(trial - {1'b0, den_reg});
        end
        else
        begin
            rem_next = trial[pes_pkg::WORD_W-1:0];
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == pes_pkg::BIT_W'(pes_pkg::WORD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            num_reg <= req.dividend;
            den_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            num_reg <= {num_reg[pes_pkg::WORD_W-2:0], 1'b0};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.rem_zero = (rem_reg == '0);

endmodule

[hw/rtl/periodic_event_scheduler.sv]
`timescale 1ns / 1ps
// Top level of the periodic event scheduler: slot table, sequencer, result register.
// Depends on pes_pkg, pes_cmd_if, pes_evt_if and pes_mod_unit.
//
// Usage:
//   cmd carries add or tick beats (valid/ready). evt carries result beats;
//   last marks the final result of each command.
//   An add is answered with one result (stored slot, or table full) in the
//   cycle after acceptance. A tick scans the slots in order; each eligible
//   slot adds one remainder computation in the shared bit-serial unit, and
//   the scan waits for it to finish. Then the results follow, one result
//   beat per cycle while evt is not stalled. cmd.ready is high only when
//   the sequencer is idle and the result register is free (empty or being
//   taken), so one command is worked on at a time. A stalled evt holds the
//   result register and freezes emission. Reset empties the table, clears
//   the tick counter and drops any result.
module periodic_event_scheduler (
    input logic       clk,
    input logic       rst_n,
    pes_cmd_if.sink   cmd,
    pes_evt_if.source evt
);

    // slot table
    logic [pes_pkg::SLOTS-1:0]    valid_reg;
    logic [pes_pkg::HND_W-1:0]    hnd_reg  [pes_pkg::SLOTS];
    logic [pes_pkg::WORD_W-1:0]   ctx_reg  [pes_pkg::SLOTS];
    logic [pes_pkg::PRIO_W-1:0]   prio_reg [pes_pkg::SLOTS];
    logic [pes_pkg::WORD_W-1:0]   ivl_reg  [pes_pkg::SLOTS];
    logic [pes_pkg::WORD_W-1:0]   tick_reg;

    // sequencer
    pes_pkg::state_t              state_reg;
    logic [pes_pkg::SLOT_W-1:0]   idx_reg;
    logic [pes_pkg::SLOTS-1:0]    pend_reg;
    logic [pes_pkg::CNT_W-1:0]    emit_cnt_reg;

    // result register
    logic                         out_valid_reg;
    pes_pkg::status_t             status_reg;
    logic [pes_pkg::OSLOT_W-1:0]  oslot_reg;
    logic [pes_pkg::HND_W-1:0]    ohnd_reg;
    logic [pes_pkg::WORD_W-1:0]   octx_reg;
    logic                         olast_reg;

    pes_pkg::div_req_t            div_req;
    pes_pkg::div_rsp_t            div_rsp;

    logic                         out_free;
    logic                         cmd_fire;
    logic                         free_found;
    logic [pes_pkg::SLOT_W-1:0]   free_idx;
    logic                         sel_found;
    logic [pes_pkg::SLOT_W-1:0]   sel_idx;
    logic [pes_pkg::SLOTS-1:0]    pend_after;
    logic                         eligible;
    logic                         idx_end;
    logic                         emit_last;

    assign out_free = !out_valid_reg || evt.ready;
    assign cmd.ready = (state_reg == pes_pkg::S_IDLE) && out_free;
    assign cmd_fire = cmd.valid && cmd.ready;
    assign idx_end = (idx_reg == pes_pkg::SLOT_W'(pes_pkg::SLOTS - 1));

    // lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = pes_pkg::SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = pes_pkg::SLOT_W'(i);
            end
        end
    end

    // next pending firing: lowest priority level, then lowest slot
    always_comb
    begin
        sel_found = 1'b0;
        sel_idx   = '0;
        for (int p = pes_pkg::PRIORITY_LEVELS - 1; p >= 0; p--)
        begin
            for (int i = pes_pkg::SLOTS - 1; i >= 0; i--)
            begin
                if (pend_reg[i] && (int'(prio_reg[i]) == p))
                begin
                    sel_found = 1'b1;
                    sel_idx   = pes_pkg::SLOT_W'(i);
                end
            end
        end
        pend_after = pend_reg;
        pend_after[sel_idx] = 1'b0;
        emit_last = (pend_after == '0) ||
                    (emit_cnt_reg == pes_pkg::CNT_W'(pes_pkg::MAX_RESULTS - 1));
    end

    // slot under scan may fire at all
    assign eligible = valid_reg[idx_reg] && (ivl_reg[idx_reg] != '0) &&
                      (int'(prio_reg[idx_reg]) < pes_pkg::PRIORITY_LEVELS);

    assign div_req.start    = (state_reg == pes_pkg::S_SCAN) && eligible;
    assign div_req.dividend = tick_reg;
    assign div_req.divisor  = ivl_reg[idx_reg];

    pes_mod_unit u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // sequencer and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pes_pkg::S_IDLE;
            valid_reg     <= '0;
            tick_reg      <= '0;
            idx_reg       <= '0;
            pend_reg      <= '0;
            emit_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (evt.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                pes_pkg::S_IDLE:
                begin
                    if (cmd_fire)
                    begin
                        if (cmd.kind == pes_pkg::KIND_ADD)
                        begin
                            out_valid_reg <= 1'b1;
                            if (free_found)
                            begin
                                valid_reg[free_idx] <= 1'b1;
                            end
                        end
                        else
                        begin
                            tick_reg     <= tick_reg + 1'b1;
                            idx_reg      <= '0;
                            pend_reg     <= '0;
                            emit_cnt_reg <= '0;
                            state_reg    <= pes_pkg::S_SCAN;
                        end
                    end
                end
                pes_pkg::S_SCAN:
                begin
                    if (eligible)
                    begin
                        state_reg <= pes_pkg::S_WAIT;
                    end
                    else if (idx_end)
                    begin
                        state_reg <= pes_pkg::S_EMIT;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                pes_pkg::S_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        pend_reg[idx_reg] <= div_rsp.rem_zero;
                        if (idx_end)
                        begin
                            state_reg <= pes_pkg::S_EMIT;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= pes_pkg::S_SCAN;
                        end
                    end
                end
                pes_pkg::S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        if (!sel_found || emit_last)
                        begin
                            state_reg <= pes_pkg::S_IDLE;
                        end
                        pend_reg     <= pend_after;
                        emit_cnt_reg <= emit_cnt_reg + 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= pes_pkg::S_IDLE;
                end
            endcase
        end
    end

    // table payload writes
    always_ff @(posedge clk)
    begin
        if (cmd_fire && (cmd.kind == pes_pkg::KIND_ADD) && free_found)
        begin
            hnd_reg[free_idx]  <= cmd.handler_id;
            ctx_reg[free_idx]  <= cmd.context_req;
            prio_reg[free_idx] <= cmd.priority_req;
            ivl_reg[free_idx]  <= cmd.interval;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (state_reg == pes_pkg::S_IDLE && cmd_fire && cmd.kind == pes_pkg::KIND_ADD)
        begin
            status_reg <= free_found ? pes_pkg::ST_STORED : pes_pkg::ST_FULL;
            oslot_reg  <= free_found ? pes_pkg::OSLOT_W'(free_idx) : '0;
            ohnd_reg   <= '0;
            octx_reg   <= '0;
            olast_reg  <= 1'b1;
        end
        else if (state_reg == pes_pkg::S_EMIT && out_free)
        begin
            if (sel_found)
            begin
                status_reg <= pes_pkg::ST_FIRED;
                oslot_reg  <= pes_pkg::OSLOT_W'(sel_idx);
                ohnd_reg   <= hnd_reg[sel_idx];
                octx_reg   <= ctx_reg[sel_idx];
                olast_reg  <= emit_last;
            end
            else
            begin
                status_reg <= pes_pkg::ST_NOTHING;
                oslot_reg  <= '0;
                ohnd_reg   <= '0;
                octx_reg   <= '0;
                olast_reg  <= 1'b1;
            end
        end
    end

    assign evt.valid         = out_valid_reg;
    assign evt.status        = status_reg;
    assign evt.slot          = oslot_reg;
    assign evt.fired_handler = ohnd_reg;
    assign evt.fired_context = octx_reg;
    assign evt.tick_count    = tick_reg;
    assign evt.last          = olast_reg;

endmodule
